### design/rtpvp_pkg.sv
// Shared constants and types for the RTP voice packetizer.
`timescale 1ns / 1ps
`default_nettype none

package rtpvp_pkg;

    // Ring geometry and packet layout
    localparam int FRAMES_DEF      = 4;
    localparam int WORDS_PER_FRAME = 40;
    localparam int PACKET_WORDS    = 43;
    localparam int HDR_WORDS       = 3;
    localparam int WCNT_W          = $clog2(WORDS_PER_FRAME);
    localparam int PWORD_W         = $clog2(PACKET_WORDS);

    // Header and payload constants
    localparam logic [7:0]  RTP_VER_BYTE = 8'h80;
    localparam logic [31:0] TS_STEP      = 32'd160;
    localparam logic [31:0] SILENCE_WORD = 32'hD5D5D5D5;

    // Configuration register reset values
    localparam logic [31:0] SSRC_RST     = 32'd0;
    localparam logic [7:0]  INTERVAL_RST = 8'd20;
    localparam logic [6:0]  PT_RST       = 7'h08;

    // Configuration register indexes
    localparam int          CFG_IDX_W    = 2;
    localparam logic [1:0]  CFG_SSRC     = 2'd0;
    localparam logic [1:0]  CFG_INTERVAL = 2'd1;
    localparam logic [1:0]  CFG_PT       = 2'd2;

    // Per-packet header fields handed from the front to the back
    typedef struct packed {
        logic [15:0] seq;
        logic [31:0] ts;
        logic        ready;
    } t_pkt_hdr;

endpackage

`default_nettype wire

### design/rtpvp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rtpvp_ram #(
    parameter int DW    = 32,
    parameter int DEPTH = 160,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/rtpvp_front.sv
// Front end: accepts beats, stores audio into the frame ring, runs session timing.
`timescale 1ns / 1ps
`default_nettype none

module rtpvp_front import rtpvp_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF,
    localparam int FW    = $clog2(FRAMES),
    localparam int AW    = $clog2(FRAMES * WORDS_PER_FRAME)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // incoming beats
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_cmd,
    input  wire logic          i_active,
    input  wire logic [31:0]   i_audio,
    input  wire logic [7:0]    i_interval,
    // frame ring write
    output logic               o_ram_we,
    output logic      [AW-1:0] o_ram_waddr,
    output logic      [31:0]   o_ram_wdata,
    // packet command queue
    output logic               o_push,
    output t_pkt_hdr           o_push_hdr,
    output logic      [FW-1:0] o_push_frame,
    input  wire logic          i_q_full,
    output logic      [FW-1:0] o_chk_frame,
    input  wire logic          i_q_hit,
    // frame in readout by the back end
    input  wire logic          i_back_busy,
    input  wire logic [FW-1:0] i_back_frame
);

    logic              r_session, n_session;
    logic [15:0]       r_seq, n_seq;
    logic [31:0]       r_ts, n_ts;
    logic [7:0]        r_tc, n_tc;
    logic [FW-1:0]     r_wf, n_wf;
    logic [WCNT_W-1:0] r_w, n_w;
    logic [FW-1:0]     r_rf, n_rf;

    logic        acc;
    logic        back_hit;
    logic [7:0]  tc_base;
    logic [7:0]  tc_inc;
    logic [15:0] seq_base;
    logic        emit;
    logic        frame_ready;

    // Hold input while the queue is full or the write frame is queued or being sent
    assign back_hit    = i_back_busy && (i_back_frame == r_wf);
    assign o_ready     = !i_q_full && !i_q_hit && !back_hit;
    assign acc         = i_valid && o_ready;
    assign o_chk_frame = r_wf;

    // Session start clears the sequence and the tick count
    assign tc_base     = r_session ? r_tc : 8'd0;
    assign seq_base    = r_session ? r_seq : 16'd0;
    assign tc_inc      = tc_base + 8'd1;
    assign emit        = acc && !i_cmd && i_active && (tc_inc >= i_interval);
    assign frame_ready = (r_wf != r_rf);

    // Audio write into the ring
    assign o_ram_we    = acc && i_cmd;
    assign o_ram_waddr = AW'(r_wf) * AW'(WORDS_PER_FRAME) + AW'(r_w);
    assign o_ram_wdata = i_audio;

    // Packet command toward the back end
    assign o_push       = emit;
    assign o_push_hdr   = {seq_base + 16'd1, r_ts + TS_STEP, frame_ready};
    assign o_push_frame = r_rf;

    // Next state of counters and pointers
    always_comb begin
        n_session = r_session;
        n_seq     = r_seq;
        n_ts      = r_ts;
        n_tc      = r_tc;
        n_wf      = r_wf;
        n_w       = r_w;
        n_rf      = r_rf;
        if (acc && i_cmd) begin
            if (r_w == WCNT_W'(WORDS_PER_FRAME - 1)) begin
                n_w  = '0;
                n_wf = (r_wf == FW'(FRAMES - 1)) ? '0 : r_wf + FW'(1);
            end else begin
                n_w = r_w + WCNT_W'(1);
            end
        end else if (acc) begin
            if (!i_active) begin
                n_session = 1'b0;
            end else begin
                n_session = 1'b1;
                if (emit) begin
                    n_tc  = 8'd0;
                    n_seq = o_push_hdr.seq;
                    n_ts  = o_push_hdr.ts;
                    if (frame_ready) begin
                        n_rf = (r_rf == FW'(FRAMES - 1)) ? '0 : r_rf + FW'(1);
                    end
                end else begin
                    n_tc  = tc_inc;
                    n_seq = seq_base;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session <= 1'b0;
            r_seq     <= '0;
            r_ts      <= '0;
            r_tc      <= '0;
            r_wf      <= '0;
            r_w       <= '0;
            r_rf      <= '0;
        end else begin
            r_session <= n_session;
            r_seq     <= n_seq;
            r_ts      <= n_ts;
            r_tc      <= n_tc;
            r_wf      <= n_wf;
            r_w       <= n_w;
            r_rf      <= n_rf;
        end
    end

endmodule

`default_nettype wire

### design/rtpvp_cmdq.sv
// Two-entry queue of packet commands between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module rtpvp_cmdq import rtpvp_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF,
    localparam int FW    = $clog2(FRAMES)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_pkt_hdr      i_push_hdr,
    input  wire logic [FW-1:0] i_push_frame,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output t_pkt_hdr           o_hdr,
    output logic      [FW-1:0] o_frame,
    input  wire logic [FW-1:0] i_chk_frame,
    output logic               o_hit
);

    logic [1:0]    r_vld, n_vld;
    logic          r_wp;
    logic          r_rp;
    t_pkt_hdr      r_hdr   [2];
    logic [FW-1:0] r_frame [2];

    assign o_full  = r_vld[r_wp];
    assign o_valid = r_vld[r_rp];
    assign o_hdr   = r_hdr[r_rp];
    assign o_frame = r_frame[r_rp];

    // Flag a queued ready frame that matches the frame being written
    always_comb begin
        o_hit = 1'b0;
        for (int i = 0; i < 2; i++) begin
            if (r_vld[i] && r_hdr[i].ready && (r_frame[i] == i_chk_frame)) begin
                o_hit = 1'b1;
            end
        end
    end

    // Entry payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_hdr[r_wp]   <= i_push_hdr;
            r_frame[r_wp] <= i_push_frame;
        end
    end

    // Set the pushed entry, clear the popped one
    always_comb begin
        n_vld = r_vld;
        if (i_push) begin
            n_vld[r_wp] = 1'b1;
        end
        if (i_pop) begin
            n_vld[r_rp] = 1'b0;
        end
    end

    // Pointers and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
        end
    end

endmodule

`default_nettype wire

### design/rtpvp_back.sv
// Back end: builds the 43-word packet from header fields and the frame ring or silence.
`timescale 1ns / 1ps
`default_nettype none

module rtpvp_back import rtpvp_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF,
    localparam int FW    = $clog2(FRAMES),
    localparam int AW    = $clog2(FRAMES * WORDS_PER_FRAME)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // command queue
    input  wire logic          i_q_valid,
    input  wire t_pkt_hdr      i_q_hdr,
    input  wire logic [FW-1:0] i_q_frame,
    output logic               o_pop,
    // frame ring read
    output logic               o_ram_re,
    output logic      [AW-1:0] o_ram_raddr,
    input  wire logic [31:0]   i_ram_rdata,
    // header configuration
    input  wire logic [31:0]   i_ssrc,
    input  wire logic [6:0]    i_pt,
    // readout status toward the front
    output logic               o_busy,
    output logic      [FW-1:0] o_frame,
    // outgoing beats
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic      [31:0]   o_data,
    output logic               o_last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } t_bk_state;

    t_bk_state          r_state;
    t_pkt_hdr           r_hdr;
    logic [FW-1:0]      r_frame;
    logic [AW-1:0]      r_addr;
    logic [PWORD_W-1:0] r_word;

    logic               r_p1_valid;
    logic               r_p1_ram;
    logic               r_p1_last;
    logic [31:0]        r_p1_word;

    logic               r_o_valid;
    logic [31:0]        r_o_data;
    logic               r_o_last;

    logic               adv;
    logic               can_issue;
    logic               issuing;
    logic               is_payload;
    logic               is_last;
    logic [31:0]        word_val;

    assign adv        = !r_o_valid || i_ready;
    assign can_issue  = !r_p1_valid || adv;
    assign issuing    = (r_state == ST_SEND) && can_issue;
    assign is_payload = (r_word >= PWORD_W'(HDR_WORDS));
    assign is_last    = (r_word == PWORD_W'(PACKET_WORDS - 1));
    assign o_pop      = (r_state == ST_IDLE) && i_q_valid;

    assign o_ram_re    = issuing && is_payload && r_hdr.ready;
    assign o_ram_raddr = r_addr;

    assign o_busy  = (r_state == ST_SEND) && r_hdr.ready;
    assign o_frame = r_frame;

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;
    assign o_last  = r_o_last;

    // Select the word for the current position
    always_comb begin
        case (r_word)
            PWORD_W'(0): word_val = {RTP_VER_BYTE, 1'b0, i_pt, r_hdr.seq};
            PWORD_W'(1): word_val = r_hdr.ts;
            PWORD_W'(2): word_val = i_ssrc;
            default:     word_val = SILENCE_WORD;
        endcase
    end

    // Sequencer: pop a command, then issue one word per free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= ST_SEND;
                    end
                end
                ST_SEND: begin
                    if (issuing && is_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Command fields and read address
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hdr   <= i_q_hdr;
            r_frame <= i_q_frame;
            r_addr  <= AW'(i_q_frame) * AW'(WORDS_PER_FRAME);
            r_word  <= '0;
        end else if (issuing) begin
            r_word <= r_word + PWORD_W'(1);
            if (is_payload) begin
                r_addr <= r_addr + AW'(1);
            end
        end
    end

    // Issue stage, aligned with the RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (can_issue) begin
            r_p1_valid <= issuing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issuing) begin
            r_p1_word <= word_val;
            r_p1_ram  <= is_payload && r_hdr.ready;
            r_p1_last <= is_last;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_data <= r_p1_ram ? i_ram_rdata : r_p1_word;
            r_o_last <= r_p1_last;
        end
    end

endmodule

`default_nettype wire

### design/rtp_voice_packetizer.sv
// A packet tick passes the command queue, sequencer, issue stage and output register.
// A packet leaves as 43 beats, one per cycle unless stalled, then the sequencer goes idle.
// Input beats are taken one per cycle, held off while the two-entry command queue is full
// or while the audio frame being written is still queued or being read for a packet.
// Reset (synchronous, active low) clears session, counters, ring pointers and queue;
// frame ring contents stay undefined and are only read after being written.
`timescale 1ns / 1ps
`default_nettype none

module rtp_voice_packetizer import rtpvp_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [31:0]          s_axis_tdata,  // [31:0] audio_word
    input  wire logic [1:0]           s_axis_tuser,  // [0] command, [1] call_active
    // output stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [31:0]          m_axis_tdata,  // [31:0] packet_word
    output logic                      m_axis_tlast,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data
);

    localparam int FW    = $clog2(FRAMES);
    localparam int DEPTH = FRAMES * WORDS_PER_FRAME;
    localparam int AW    = $clog2(DEPTH);

    logic [31:0]   r_ssrc;
    logic [7:0]    r_interval;
    logic [6:0]    r_pt;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic          push;
    t_pkt_hdr      push_hdr;
    logic [FW-1:0] push_frame;
    logic          q_full;
    logic [FW-1:0] chk_frame;
    logic          q_hit;
    logic          pop;
    logic          q_valid;
    t_pkt_hdr      q_hdr;
    logic [FW-1:0] q_frame;
    logic          back_busy;
    logic [FW-1:0] back_frame;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ssrc     <= SSRC_RST;
            r_interval <= INTERVAL_RST;
            r_pt       <= PT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SSRC:     r_ssrc     <= i_cfg_data;
                CFG_INTERVAL: r_interval <= i_cfg_data[7:0];
                CFG_PT:       r_pt       <= i_cfg_data[6:0];
                default:      ;
            endcase
        end
    end

    rtpvp_front #(
        .FRAMES (FRAMES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (s_axis_tuser[0]),
        .i_active     (s_axis_tuser[1]),
        .i_audio      (s_axis_tdata),
        .i_interval   (r_interval),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_push       (push),
        .o_push_hdr   (push_hdr),
        .o_push_frame (push_frame),
        .i_q_full     (q_full),
        .o_chk_frame  (chk_frame),
        .i_q_hit      (q_hit),
        .i_back_busy  (back_busy),
        .i_back_frame (back_frame)
    );

    rtpvp_cmdq #(
        .FRAMES (FRAMES)
    ) u_cmdq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_hdr   (push_hdr),
        .i_push_frame (push_frame),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_valid      (q_valid),
        .o_hdr        (q_hdr),
        .o_frame      (q_frame),
        .i_chk_frame  (chk_frame),
        .o_hit        (q_hit)
    );

    rtpvp_ram #(
        .DW    (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rtpvp_back #(
        .FRAMES (FRAMES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_hdr     (q_hdr),
        .i_q_frame   (q_frame),
        .o_pop       (pop),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .i_ssrc      (r_ssrc),
        .i_pt        (r_pt),
        .o_busy      (back_busy),
        .o_frame     (back_frame),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule

`default_nettype wire

### design/rtpvp_checker.sv
// Port-level checks for the RTP voice packetizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rtpvp_checker import rtpvp_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    logic [PWORD_W-1:0] r_cnt;
    logic               beat;

    assign beat = m_axis_tvalid && m_axis_tready;

    // Track the beat position within a packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (beat) begin
            r_cnt <= (r_cnt == PWORD_W'(PACKET_WORDS - 1)) ? '0 : r_cnt + PWORD_W'(1);
        end
    end

    // A stalled beat stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat withdrawn while stalled");

    // A stalled beat keeps its payload
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

    // Every packet is exactly 43 beats long
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (r_cnt == PWORD_W'(PACKET_WORDS - 1))))
        else $error("last flag out of place");

    // Every packet opens with the RTP version byte
    a_version: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_cnt == '0) |-> (m_axis_tdata[31:24] == RTP_VER_BYTE))
        else $error("packet does not open with the version byte");

endmodule

bind rtp_voice_packetizer rtpvp_checker u_rtpvp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
